[design/hrss_pkg.sv]
package hrss_pkg;

   localparam logic [5:0] CODE_INPUT        = 6'h20;
   localparam logic [5:0] CODE_REPORT_ID    = 6'h21;
   localparam logic [5:0] CODE_OUTPUT       = 6'h24;
   localparam logic [5:0] CODE_REPORT_COUNT = 6'h25;
   localparam logic [5:0] CODE_FEATURE      = 6'h2C;
   localparam logic [5:0] CODE_REPORT_SIZE  = 6'h1D;

   localparam logic [1:0] STATUS_FOUND     = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam int BYTE_COUNT_WIDTH = 30;

   typedef logic [BYTE_COUNT_WIDTH-1:0] byte_count_type;

   function automatic logic [2:0] value_length(input logic [1:0] size_code);
      logic [2:0] len;
      case (size_code)
         2'd0: len = 3'd0;
         2'd1: len = 3'd1;
         2'd2: len = 3'd2;
         2'd3: len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [31:0] saturate_product(input logic [63:0] prod);
      logic [31:0] res;
      res = (prod[63:32] != 32'd0) ? 32'hFFFF_FFFF : prod[31:0];
      return res;
   endfunction

   function automatic logic [31:0] saturate_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic byte_count_type bits_to_bytes(input logic [31:0] bits,
                                                     input logic id_byte);
      logic [32:0] sum;
      byte_count_type n;
      sum = {1'b0, bits} + 33'd7;
      n = sum[32:3];
      if (n != '0 && id_byte) begin
         n = n + byte_count_type'(1);
      end
      return n;
   endfunction

endpackage

[design/hid_report_size_scanner.sv]
// a byte is taken into an input register and processed from there; the result of a final
// byte is registered and appears on rsp_valid once any earlier result has been taken
// throughput: one descriptor byte per cycle unless a final byte waits on an untaken result,
// set by the combinational item update, size times count product in a register ahead of use
// reset: synchronous, active high; clears scan state, the register and both channels
module hid_report_size_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_desc_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [29:0] rsp_input_bytes,
   output logic [29:0] rsp_output_bytes,
   output logic [29:0] rsp_feature_bytes
);

   logic [7:0]  wanted_id_ff;

   logic        stage_valid_ff, stage_valid_in;
   logic [7:0]  stage_byte_ff;
   logic        stage_last_ff;

   logic [2:0]  left_ff, left_in;
   logic [1:0]  index_ff, index_in;
   logic [5:0]  code_ff, code_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] cur_id_ff, cur_id_in;
   logic [31:0] field_bits_ff, field_bits_in;
   logic [31:0] field_repeat_ff, field_repeat_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] in_total_ff, in_total_in;
   logic [31:0] out_total_ff, out_total_in;
   logic [31:0] feat_total_ff, feat_total_in;
   logic        seen_ff, seen_in;
   logic        stopped_ff, stopped_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [29:0] rsp_in_bytes_ff, rsp_in_bytes_in;
   logic [29:0] rsp_out_bytes_ff, rsp_out_bytes_in;
   logic [29:0] rsp_feat_bytes_ff, rsp_feat_bytes_in;

   logic        req_fire;
   logic        stage_go;
   logic        finish;
   logic [5:0]  fin_code;
   logic [31:0] fin_val;
   logic [31:0] shifted;
   logic        match;
   logic [1:0]  status;

   assign stage_go  = stage_valid_ff && (!stage_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || stage_go;
   assign req_fire  = req_valid && req_ready;

   assign stage_valid_in = req_fire ? 1'b1 : (stage_go ? 1'b0 : stage_valid_ff);

   assign shifted = {24'd0, stage_byte_ff} << {index_ff, 3'b000};
   assign match   = (cur_id_ff == {24'd0, wanted_id_ff});

   always_comb begin
      left_in         = left_ff;
      index_in        = index_ff;
      code_in         = code_ff;
      accum_in        = accum_ff;
      cur_id_in       = cur_id_ff;
      field_bits_in   = field_bits_ff;
      field_repeat_in = field_repeat_ff;
      prod_in         = prod_ff;
      in_total_in     = in_total_ff;
      out_total_in    = out_total_ff;
      feat_total_in   = feat_total_ff;
      seen_in         = seen_ff;
      stopped_in      = stopped_ff;
      finish          = 1'b0;
      fin_code        = code_ff;
      fin_val         = 32'd0;

      if (!stopped_ff) begin
         if (left_ff == 3'd0) begin
            code_in  = stage_byte_ff[7:2];
            accum_in = 32'd0;
            index_in = 2'd0;
            left_in  = hrss_pkg::value_length(stage_byte_ff[1:0]);
            finish   = (stage_byte_ff[1:0] == 2'd0);
            fin_code = stage_byte_ff[7:2];
            fin_val  = 32'd0;
         end else begin
            accum_in = accum_ff | shifted;
            index_in = index_ff + 2'd1;
            left_in  = left_ff - 3'd1;
            finish   = (left_ff == 3'd1);
            fin_code = code_ff;
            fin_val  = accum_ff | shifted;
         end
      end

      if (finish) begin
         case (fin_code)
            hrss_pkg::CODE_REPORT_ID: begin
               if (wanted_id_ff == 8'd0) begin
                  stopped_in = 1'b1;
               end else begin
                  cur_id_in = fin_val;
                  if (fin_val == {24'd0, wanted_id_ff}) begin
                     seen_in = 1'b1;
                  end
               end
            end
            hrss_pkg::CODE_INPUT: begin
               if (match) begin
                  in_total_in = hrss_pkg::saturate_add(in_total_ff, prod_ff);
               end
            end
            hrss_pkg::CODE_OUTPUT: begin
               if (match) begin
                  out_total_in = hrss_pkg::saturate_add(out_total_ff, prod_ff);
               end
            end
            hrss_pkg::CODE_FEATURE: begin
               if (match) begin
                  feat_total_in = hrss_pkg::saturate_add(feat_total_ff, prod_ff);
               end
            end
            hrss_pkg::CODE_REPORT_COUNT: begin
               field_repeat_in = fin_val;
               prod_in = hrss_pkg::saturate_product(64'(field_bits_ff) * 64'(fin_val));
            end
            hrss_pkg::CODE_REPORT_SIZE: begin
               field_bits_in = fin_val;
               prod_in = hrss_pkg::saturate_product(64'(fin_val) * 64'(field_repeat_ff));
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (stopped_in) begin
         status = hrss_pkg::STATUS_NOT_FOUND;
      end else if (left_in != 3'd0) begin
         status = hrss_pkg::STATUS_TRUNCATED;
      end else if (wanted_id_ff == 8'd0 || seen_in) begin
         status = hrss_pkg::STATUS_FOUND;
      end else begin
         status = hrss_pkg::STATUS_NOT_FOUND;
      end
   end

   always_comb begin
      rsp_status_in     = status;
      rsp_in_bytes_in   = '0;
      rsp_out_bytes_in  = '0;
      rsp_feat_bytes_in = '0;
      if (status == hrss_pkg::STATUS_FOUND) begin
         rsp_in_bytes_in   = hrss_pkg::bits_to_bytes(in_total_in, wanted_id_ff != 8'd0);
         rsp_out_bytes_in  = hrss_pkg::bits_to_bytes(out_total_in, wanted_id_ff != 8'd0);
         rsp_feat_bytes_in = hrss_pkg::bits_to_bytes(feat_total_in, wanted_id_ff != 8'd0);
      end
   end

   assign rsp_valid_in = (stage_go && stage_last_ff) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_id_ff <= 8'd0;
      end else if (csr_write_enable) begin
         wanted_id_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_byte_ff <= req_desc_byte;
         stage_last_ff <= req_last_byte;
      end
      if (stage_go && stage_last_ff) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_in_bytes_ff   <= rsp_in_bytes_in;
         rsp_out_bytes_ff  <= rsp_out_bytes_in;
         rsp_feat_bytes_ff <= rsp_feat_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (stage_go && stage_last_ff)) begin
         left_ff         <= 3'd0;
         index_ff        <= 2'd0;
         code_ff         <= 6'd0;
         accum_ff        <= 32'd0;
         cur_id_ff       <= 32'd0;
         field_bits_ff   <= 32'd0;
         field_repeat_ff <= 32'd0;
         prod_ff         <= 32'd0;
         in_total_ff     <= 32'd0;
         out_total_ff    <= 32'd0;
         feat_total_ff   <= 32'd0;
         seen_ff         <= 1'b0;
         stopped_ff      <= 1'b0;
      end else if (stage_go) begin
         left_ff         <= left_in;
         index_ff        <= index_in;
         code_ff         <= code_in;
         accum_ff        <= accum_in;
         cur_id_ff       <= cur_id_in;
         field_bits_ff   <= field_bits_in;
         field_repeat_ff <= field_repeat_in;
         prod_ff         <= prod_in;
         in_total_ff     <= in_total_in;
         out_total_ff    <= out_total_in;
         feat_total_ff   <= feat_total_in;
         seen_ff         <= seen_in;
         stopped_ff      <= stopped_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_input_bytes   = rsp_in_bytes_ff;
   assign rsp_output_bytes  = rsp_out_bytes_ff;
   assign rsp_feature_bytes = rsp_feat_bytes_ff;

`ifndef NO_ASSERTIONS
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= 3'd4)
      else $error("value byte count out of range");

   a_prod_tracks_fields: assert property (@(posedge clock) disable iff (reset)
      prod_ff == hrss_pkg::saturate_product(64'(field_bits_ff) * 64'(field_repeat_ff)))
      else $error("stored product out of step with size and count");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (stage_go && stage_last_ff) |=> (left_ff == 3'd0 && !stopped_ff && !seen_ff
                                       && in_total_ff == 32'd0 && rsp_valid_ff))
      else $error("scan state not cleared after final byte");

   a_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != hrss_pkg::STATUS_FOUND) |->
         (rsp_in_bytes_ff == '0 && rsp_out_bytes_ff == '0 && rsp_feat_bytes_ff == '0))
      else $error("nonzero length with status other than found");

   a_no_stall_without_result: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_go) |-> (stage_last_ff && rsp_valid_ff && !rsp_ready))
      else $error("byte stalled while result side free");
`endif

endmodule

[tb/tb_hid_report_size_scanner.sv]
module tb_hid_report_size_scanner;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PHASE = 488;

   typedef struct packed {
      logic [1:0]               status;
      hrss_pkg::byte_count_type in_len;
      hrss_pkg::byte_count_type out_len;
      hrss_pkg::byte_count_type feat_len;
   } report_lengths_type;

   typedef enum logic [1:0] {ROW_CFG, ROW_MID, ROW_END, ROW_END_TYPED} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [7:0]         value;
      report_lengths_type typed_res;
   } directed_row_type;

   localparam report_lengths_type NO_LENGTHS = '0;
   localparam hrss_pkg::byte_count_type MAX_LEN = 30'd536870913;

   localparam directed_row_type DIRECTED_ROWS [28] = '{
      '{ROW_CFG,       8'h00, NO_LENGTHS},
      // empty item alone
      '{ROW_END_TYPED, 8'h00, '{hrss_pkg::STATUS_FOUND, 30'd0, 30'd0, 30'd0}},
      // prefix announcing four bytes, then end
      '{ROW_END_TYPED, 8'hFF, '{hrss_pkg::STATUS_TRUNCATED, 30'd0, 30'd0, 30'd0}},
      // size 8, count 3, input
      '{ROW_MID,       8'h75, NO_LENGTHS},
      '{ROW_MID,       8'h08, NO_LENGTHS},
      '{ROW_MID,       8'h95, NO_LENGTHS},
      '{ROW_MID,       8'h03, NO_LENGTHS},
      '{ROW_MID,       8'h81, NO_LENGTHS},
      '{ROW_END,       8'h02, NO_LENGTHS},
      // report id with no id configured stops the scan
      '{ROW_MID,       8'h85, NO_LENGTHS},
      '{ROW_MID,       8'h01, NO_LENGTHS},
      '{ROW_END_TYPED, 8'hFF, '{hrss_pkg::STATUS_NOT_FOUND, 30'd0, 30'd0, 30'd0}},
      '{ROW_CFG,       8'hFF, NO_LENGTHS},
      // saturating size times count on feature and output
      '{ROW_MID,       8'h85, NO_LENGTHS},
      '{ROW_MID,       8'hFF, NO_LENGTHS},
      '{ROW_MID,       8'h77, NO_LENGTHS},
      '{ROW_MID,       8'hFF, NO_LENGTHS},
      '{ROW_MID,       8'hFF, NO_LENGTHS},
      '{ROW_MID,       8'hFF, NO_LENGTHS},
      '{ROW_MID,       8'hFF, NO_LENGTHS},
      '{ROW_MID,       8'h97, NO_LENGTHS},
      '{ROW_MID,       8'hFF, NO_LENGTHS},
      '{ROW_MID,       8'hFF, NO_LENGTHS},
      '{ROW_MID,       8'hFF, NO_LENGTHS},
      '{ROW_MID,       8'hFF, NO_LENGTHS},
      '{ROW_MID,       8'hB0, NO_LENGTHS},
      '{ROW_END_TYPED, 8'h90, '{hrss_pkg::STATUS_FOUND, 30'd0, MAX_LEN, MAX_LEN}},
      // wanted id never seen
      '{ROW_END_TYPED, 8'h00, '{hrss_pkg::STATUS_NOT_FOUND, 30'd0, 30'd0, 30'd0}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_desc_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [1:0]  rsp_status;
   logic [29:0] rsp_input_bytes;
   logic [29:0] rsp_output_bytes;
   logic [29:0] rsp_feature_bytes;

   hid_report_size_scanner dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_desc_byte     (req_desc_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_input_bytes   (rsp_input_bytes),
      .rsp_output_bytes  (rsp_output_bytes),
      .rsp_feature_bytes (rsp_feature_bytes)
   );

   always #4 clock = ~clock;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int cycles = 0;

   report_lengths_type lengths_pending [$];
   logic [7:0]         desc_q [$];

   // scanner shadow state
   logic [7:0]  wanted_id = 8'd0;
   logic [2:0]  bytes_left;
   logic [1:0]  byte_idx;
   logic [5:0]  pending_code;
   logic [31:0] accum;
   logic [31:0] cur_id;
   logic [31:0] size_bits;
   logic [31:0] count_rep;
   logic [31:0] in_bits;
   logic [31:0] out_bits;
   logic [31:0] feat_bits;
   logic        id_matched;
   logic        halted;

   function automatic void clear_scan_state();
      bytes_left = '0;
      byte_idx = '0;
      pending_code = '0;
      accum = '0;
      cur_id = '0;
      size_bits = '0;
      count_rep = '0;
      in_bits = '0;
      out_bits = '0;
      feat_bits = '0;
      id_matched = 1'b0;
      halted = 1'b0;
   endfunction

   function automatic logic [31:0] add_saturated(logic [31:0] total);
      logic [63:0] prod;
      logic [32:0] sum;
      prod = {32'd0, size_bits} * {32'd0, count_rep};
      if (prod[63:32] != 32'd0) begin
         prod = 64'h0000_0000_FFFF_FFFF;
      end
      sum = {1'b0, total} + {1'b0, prod[31:0]};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic hrss_pkg::byte_count_type to_byte_count(logic [31:0] bits);
      logic [32:0] n;
      n = ({1'b0, bits} + 33'd7) >> 3;
      if (n != 33'd0 && wanted_id != 8'd0) begin
         n = n + 33'd1;
      end
      return n[29:0];
   endfunction

   function automatic void finish_item();
      logic match;
      match = (cur_id == {24'd0, wanted_id});
      case (pending_code)
         hrss_pkg::CODE_REPORT_ID: begin
            if (wanted_id == 8'd0) begin
               halted = 1'b1;
            end else begin
               cur_id = accum;
               if (accum == {24'd0, wanted_id}) begin
                  id_matched = 1'b1;
               end
            end
         end
         hrss_pkg::CODE_INPUT: begin
            if (match) in_bits = add_saturated(in_bits);
         end
         hrss_pkg::CODE_OUTPUT: begin
            if (match) out_bits = add_saturated(out_bits);
         end
         hrss_pkg::CODE_FEATURE: begin
            if (match) feat_bits = add_saturated(feat_bits);
         end
         hrss_pkg::CODE_REPORT_COUNT: count_rep = accum;
         hrss_pkg::CODE_REPORT_SIZE: size_bits = accum;
         default: ;
      endcase
   endfunction

   function automatic bit predict_report(logic [7:0] b, logic last,
                                         output report_lengths_type res);
      res = '0;
      if (!halted) begin
         if (bytes_left == 3'd0) begin
            pending_code = b[7:2];
            accum = '0;
            byte_idx = '0;
            case (b[1:0])
               2'd0: bytes_left = 3'd0;
               2'd1: bytes_left = 3'd1;
               2'd2: bytes_left = 3'd2;
               default: bytes_left = 3'd4;
            endcase
            if (bytes_left == 3'd0) finish_item();
         end else begin
            accum = accum | ({24'd0, b} << (8 * byte_idx));
            byte_idx = byte_idx + 2'd1;
            bytes_left = bytes_left - 3'd1;
            if (bytes_left == 3'd0) finish_item();
         end
      end
      if (!last) return 1'b0;
      if (halted) begin
         res.status = hrss_pkg::STATUS_NOT_FOUND;
      end else if (bytes_left != 3'd0) begin
         res.status = hrss_pkg::STATUS_TRUNCATED;
      end else if (wanted_id == 8'd0 || id_matched) begin
         res.status = hrss_pkg::STATUS_FOUND;
         res.in_len = to_byte_count(in_bits);
         res.out_len = to_byte_count(out_bits);
         res.feat_len = to_byte_count(feat_bits);
      end else begin
         res.status = hrss_pkg::STATUS_NOT_FOUND;
      end
      clear_scan_state();
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_wanted();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'hFF;
         2: return 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed items, some raw noise, sometimes cut short
   task automatic build_descriptor();
      int n_items;
      int pick;
      int nlen;
      int cut;
      logic [1:0]  lc;
      logic [31:0] v;
      logic [5:0]  code;
      desc_q.delete();
      n_items = $urandom_range(1, 12);
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         lc = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) v = $urandom;
         else v = $urandom_range(0, 40);
         if (pick < 20) begin
            code = hrss_pkg::CODE_REPORT_SIZE;
         end else if (pick < 40) begin
            code = hrss_pkg::CODE_REPORT_COUNT;
         end else if (pick < 52) begin
            code = hrss_pkg::CODE_REPORT_ID;
            if (wanted_id == 8'd0 && $urandom_range(0, 3) != 0) begin
               code = hrss_pkg::CODE_INPUT;
            end else if (wanted_id != 8'd0 && $urandom_range(0, 2) != 0) begin
               v = {24'd0, wanted_id};
               if (lc == 2'd0) lc = 2'd1;
            end
         end else if (pick < 67) begin
            code = hrss_pkg::CODE_INPUT;
         end else if (pick < 77) begin
            code = hrss_pkg::CODE_OUTPUT;
         end else if (pick < 87) begin
            code = hrss_pkg::CODE_FEATURE;
         end else if (pick < 95) begin
            code = 6'($urandom_range(0, 63));
         end else begin
            desc_q.push_back(8'($urandom_range(0, 255)));
            continue;
         end
         nlen = (lc == 2'd3) ? 4 : int'(lc);
         desc_q.push_back({code, lc});
         for (int k = 0; k < nlen; k++) begin
            desc_q.push_back(v[8*k +: 8]);
         end
      end
      if ($urandom_range(0, 9) == 0 && desc_q.size() > 1) begin
         cut = $urandom_range(1, (desc_q.size() - 1 < 3) ? desc_q.size() - 1 : 3);
         repeat (cut) void'(desc_q.pop_back());
      end
   endtask

   task automatic send_byte(logic [7:0] b, logic last, bit use_typed,
                            report_lengths_type typed_res);
      report_lengths_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_desc_byte = b;
      req_last_byte = last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_report(b, last, predicted)) begin
         lengths_pending.push_back(use_typed ? typed_res : predicted);
      end
      @(negedge clock);
   endtask

   task automatic wait_idle(int settle);
      req_valid = 1'b0;
      while (lengths_pending.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_wanted(logic [7:0] id);
      wait_idle(4);
      csr_write_enable = 1'b1;
      csr_write_data = id;
      @(negedge clock);
      csr_write_enable = 1'b0;
      wanted_id = id;
   endtask

   task automatic compare_field(string name, logic [29:0] want, logic [29:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      report_lengths_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lengths_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: expected none, got status %0d", rsp_status);
            end
         end else begin
            want = lengths_pending.pop_front();
            compare_field("status", 30'(want.status), 30'(rsp_status));
            compare_field("input_bytes", want.in_len, rsp_input_bytes);
            compare_field("output_bytes", want.out_len, rsp_output_bytes);
            compare_field("feature_bytes", want.feat_len, rsp_feature_bytes);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int sent;
      clear_scan_state();
      repeat (3) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         case (DIRECTED_ROWS[i].kind)
            ROW_CFG: write_wanted(DIRECTED_ROWS[i].value);
            ROW_MID: send_byte(DIRECTED_ROWS[i].value, 1'b0, 1'b0, NO_LENGTHS);
            ROW_END: send_byte(DIRECTED_ROWS[i].value, 1'b1, 1'b0, NO_LENGTHS);
            default: begin
               send_byte(DIRECTED_ROWS[i].value, 1'b1, 1'b1, DIRECTED_ROWS[i].typed_res);
            end
         endcase
      end

      for (int phase = 0; phase < 4; phase++) begin
         wait_idle(4);
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         write_wanted(pick_wanted());
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 7) == 0) write_wanted(pick_wanted());
            build_descriptor();
            foreach (desc_q[k]) begin
               send_byte(desc_q[k], k == desc_q.size() - 1, 1'b0, NO_LENGTHS);
            end
            sent += desc_q.size();
         end
      end

      wait_idle(8);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
